FILE: hdl/dbcs_charset_first_match_assert.svh
// Assertion macros shared by the RTL; they expect clk and rst_n in scope.
`ifndef DBCS_CHARSET_FIRST_MATCH_ASSERT_SVH
`define DBCS_CHARSET_FIRST_MATCH_ASSERT_SVH

`ifndef SYNTHESIS
`define DCFM_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dcfm invariant violated");
`define DCFM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcfm sequence violated");
`else
`define DCFM_ASSERT(lbl, expr)
`define DCFM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/dcfm_pkg.sv
package dcfm_pkg;

    localparam int DEF_SET_ENTRIES    = 32;
    localparam int DEF_POSITION_WIDTH = 16;
    localparam int OUT_POS_W          = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_HIGH = 2'd3;

    localparam logic [7:0] RST_A_LOW  = 8'd129;
    localparam logic [7:0] RST_A_HIGH = 8'd159;
    localparam logic [7:0] RST_B_LOW  = 8'd224;
    localparam logic [7:0] RST_B_HIGH = 8'd252;

    localparam logic OP_CONTROL = 1'b0;
    localparam logic OP_STRING  = 1'b1;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
        logic       is_pair;
    } entry_t;

    function automatic logic is_lead(
        input logic [7:0] b,
        input logic [7:0] a_lo,
        input logic [7:0] a_hi,
        input logic [7:0] b_lo,
        input logic [7:0] b_hi
    );
        return ((a_lo <= b) && (b <= a_hi)) || ((b_lo <= b) && (b <= b_hi));
    endfunction

endpackage

FILE: hdl/dcfm_cell.sv
module dcfm_cell (
    input  logic             clk,
    input  logic             shift_en,
    input  dcfm_pkg::entry_t entry_in,
    input  logic             live,
    input  dcfm_pkg::entry_t query,
    output dcfm_pkg::entry_t entry_out,
    output logic             hit
);
    import dcfm_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out = entry_reg;

    // trail only counts for pair entries
    assign hit = live
               && (entry_reg.is_pair == query.is_pair)
               && (entry_reg.lead == query.lead)
               && (!query.is_pair || (entry_reg.trail == query.trail));

endmodule

FILE: hdl/dcfm_cell_row.sv
module dcfm_cell_row #(
    parameter int SET_ENTRIES = dcfm_pkg::DEF_SET_ENTRIES,
    parameter int CNT_W       = $clog2(SET_ENTRIES + 1)
) (
    input  logic             clk,
    input  logic             shift_en,
    input  dcfm_pkg::entry_t new_entry,
    input  logic [CNT_W-1:0] count,
    input  dcfm_pkg::entry_t query,
    output logic             hit
);
    import dcfm_pkg::*;

    entry_t                 chain [SET_ENTRIES];
    logic [SET_ENTRIES-1:0] live;
    logic [SET_ENTRIES-1:0] hit_vec;

    // newest entry enters at cell 0; live cells are 0 .. count-1
    for (genvar i = 0; i < SET_ENTRIES; i++)
    begin : g_cell
        entry_t cell_in;
        if (i == 0)
        begin : g_head
            assign cell_in = new_entry;
        end
        else
        begin : g_body
            assign cell_in = chain[i-1];
        end

        assign live[i] = (count > CNT_W'(i));

        dcfm_cell u_cell (
            .clk       (clk),
            .shift_en  (shift_en),
            .entry_in  (cell_in),
            .live      (live[i]),
            .query     (query),
            .entry_out (chain[i]),
            .hit       (hit_vec[i])
        );
    end

    assign hit = |hit_vec;

endmodule

FILE: hdl/dbcs_charset_first_match.sv
// Searches a byte string for the first character in a control set, where a
// character is one byte or a lead+trail pair (lead bytes lie in one of two
// configurable ranges). Send the control set as op=0 words ending in a zero,
// then the string as op=1 words ending in a zero. One word is taken per clock;
// the set lives in a row of SET_ENTRIES cells, new entries shift in at the
// head, and every cell compares the current character in the same cycle, so
// the match is known in the cycle the word is taken and the result word
// appears on the next cycle. A result comes on each match (the scan then
// starts over at position 0) and at the terminator with found=0. While a
// result waits and out_ready is low, no input word is taken.
module dbcs_charset_first_match #(
    parameter int SET_ENTRIES    = dcfm_pkg::DEF_SET_ENTRIES,
    parameter int POSITION_WIDTH = dcfm_pkg::DEF_POSITION_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dcfm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dcfm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               op,
    input  logic [7:0]                         byte_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [dcfm_pkg::OUT_POS_W-1:0]     match_position,
    output logic                               set_overflowed
);
    import dcfm_pkg::*;

    localparam int CNT_W = $clog2(SET_ENTRIES + 1);
    localparam int EXT_W = (POSITION_WIDTH > OUT_POS_W) ? POSITION_WIDTH : OUT_POS_W;

    logic [7:0] a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      cpend_vld_reg, cpend_vld_next;
    logic [7:0]                cpend_lead_reg, cpend_lead_next;
    logic                      closed_reg, closed_next;
    logic                      ovf_reg, ovf_next;
    logic                      spend_vld_reg, spend_vld_next;
    logic [7:0]                spend_lead_reg, spend_lead_next;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic                      fin_reg, fin_next;

    logic                      out_valid_reg, out_valid_next;
    logic                      found_reg, found_next;
    logic [OUT_POS_W-1:0]      opos_reg, opos_next;
    logic                      oovf_reg, oovf_next;

    logic                      accept;
    logic                      lead_byte;
    logic                      shift_en;
    entry_t                    new_entry;
    entry_t                    query;
    logic                      hit;
    logic                      done;
    logic                      done_hit;
    logic [CNT_W-1:0]          base_count;
    logic [POSITION_WIDTH-1:0] base_pos;
    logic [1:0]                step;
    logic [POSITION_WIDTH:0]   pos_sum;
    logic [EXT_W-1:0]          pos_ext;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign lead_byte = is_lead(byte_value, a_lo_reg, a_hi_reg, b_lo_reg, b_hi_reg);

    // string lookup key: pending lead + this byte, or this byte alone
    always_comb
    begin
        query.lead    = spend_vld_reg ? spend_lead_reg : byte_value;
        query.trail   = spend_vld_reg ? byte_value : 8'd0;
        query.is_pair = spend_vld_reg;
    end

    dcfm_cell_row #(
        .SET_ENTRIES (SET_ENTRIES),
        .CNT_W       (CNT_W)
    ) u_row (
        .clk       (clk),
        .shift_en  (shift_en),
        .new_entry (new_entry),
        .count     (count_reg),
        .query     (query),
        .hit       (hit)
    );

    assign base_pos = fin_reg ? '0 : pos_reg;
    assign pos_sum  = {1'b0, base_pos} + (POSITION_WIDTH + 1)'(step);
    assign pos_ext  = EXT_W'(base_pos);

    always_comb
    begin
        count_next      = count_reg;
        cpend_vld_next  = cpend_vld_reg;
        cpend_lead_next = cpend_lead_reg;
        closed_next     = closed_reg;
        ovf_next        = ovf_reg;
        spend_vld_next  = spend_vld_reg;
        spend_lead_next = spend_lead_reg;
        pos_next        = pos_reg;
        fin_next        = fin_reg;
        shift_en        = 1'b0;
        new_entry       = '{lead: byte_value, trail: 8'd0, is_pair: 1'b0};
        done            = 1'b0;
        done_hit        = 1'b0;
        step            = 2'd0;
        base_count      = closed_reg ? '0 : count_reg;

        if (accept && (op == OP_CONTROL))
        begin
            if (closed_reg)
            begin
                // opening a new set wipes the old one and any scan in flight
                count_next     = '0;
                cpend_vld_next = 1'b0;
                ovf_next       = 1'b0;
                closed_next    = 1'b0;
                spend_vld_next = 1'b0;
                pos_next       = '0;
                fin_next       = 1'b0;
            end
            priority if (byte_value == 8'd0)
            begin
                cpend_vld_next = 1'b0;
                closed_next    = 1'b1;
            end
            else if (cpend_vld_reg && !closed_reg)
            begin
                new_entry      = '{lead: cpend_lead_reg, trail: byte_value, is_pair: 1'b1};
                cpend_vld_next = 1'b0;
                if (base_count == CNT_W'(SET_ENTRIES))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    shift_en   = 1'b1;
                    count_next = base_count + CNT_W'(1);
                end
            end
            else if (lead_byte)
            begin
                cpend_vld_next  = 1'b1;
                cpend_lead_next = byte_value;
            end
            else
            begin
                if (base_count == CNT_W'(SET_ENTRIES))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    shift_en   = 1'b1;
                    count_next = base_count + CNT_W'(1);
                end
            end
        end
        else if (accept)
        begin
            pos_next = base_pos;
            fin_next = 1'b0;
            // after a finished scan the pending lead is already clear
            priority if (byte_value == 8'd0)
            begin
                done = 1'b1;
            end
            else if (spend_vld_reg)
            begin
                if (hit)
                begin
                    done     = 1'b1;
                    done_hit = 1'b1;
                end
                else
                begin
                    spend_vld_next = 1'b0;
                    step           = 2'd2;
                end
            end
            else if (lead_byte)
            begin
                spend_vld_next  = 1'b1;
                spend_lead_next = byte_value;
            end
            else if (hit)
            begin
                done     = 1'b1;
                done_hit = 1'b1;
            end
            else
            begin
                step = 2'd1;
            end

            if (step != 2'd0)
            begin
                pos_next = pos_sum[POSITION_WIDTH] ? '1 : pos_sum[POSITION_WIDTH-1:0];
            end
            if (done)
            begin
                spend_vld_next = 1'b0;
                fin_next       = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        opos_next      = opos_reg;
        oovf_next      = oovf_reg;
        if (accept && done)
        begin
            out_valid_next = 1'b1;
            found_next     = done_hit;
            opos_next      = done_hit ? pos_ext[OUT_POS_W-1:0] : '0;
            oovf_next      = ovf_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_lo_reg      <= RST_A_LOW;
            a_hi_reg      <= RST_A_HIGH;
            b_lo_reg      <= RST_B_LOW;
            b_hi_reg      <= RST_B_HIGH;
            count_reg     <= '0;
            cpend_vld_reg <= 1'b0;
            closed_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
            spend_vld_reg <= 1'b0;
            pos_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_A_LOW:  a_lo_reg <= cfg_data;
                    REG_A_HIGH: a_hi_reg <= cfg_data;
                    REG_B_LOW:  b_lo_reg <= cfg_data;
                    REG_B_HIGH: b_hi_reg <= cfg_data;
                    default:    a_lo_reg <= a_lo_reg;
                endcase
            end
            count_reg     <= count_next;
            cpend_vld_reg <= cpend_vld_next;
            closed_reg    <= closed_next;
            ovf_reg       <= ovf_next;
            spend_vld_reg <= spend_vld_next;
            pos_reg       <= pos_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cpend_lead_reg <= cpend_lead_next;
        spend_lead_reg <= spend_lead_next;
        found_reg      <= found_next;
        opos_reg       <= opos_next;
        oovf_reg       <= oovf_next;
    end

    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign match_position = opos_reg;
    assign set_overflowed = oovf_reg;

`include "dbcs_charset_first_match_assert.svh"

    `DCFM_ASSERT(a_count_bound, count_reg <= CNT_W'(SET_ENTRIES))
    `DCFM_ASSERT(a_ovf_full, !ovf_reg || closed_reg || (count_reg == CNT_W'(SET_ENTRIES)))
    `DCFM_ASSERT(a_miss_pos_zero, !out_valid_reg || found_reg || (opos_reg == '0))
    `DCFM_ASSERT_NEXT(a_term_result, accept && (op == OP_STRING) && (byte_value == 8'd0), out_valid_reg && !found_reg)
    `DCFM_ASSERT_NEXT(a_done_finishes, accept && done, fin_reg && !spend_vld_reg)

endmodule

FILE: dv/dbcs_charset_first_match_test.sv
module dbcs_charset_first_match_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcfm_pkg::*;

    localparam int          SET_CAP          = DEF_SET_ENTRIES;
    localparam int unsigned POS_MAX          = (32'd1 << DEF_POSITION_WIDTH) - 1;
    localparam logic [7:0]  TERMINATOR       = 8'h00;
    localparam int          RESET_CYCLES     = 10;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          SEGMENTS         = 9;
    localparam int          SEGMENT_WORDS    = 120;
    localparam longint      TIMEOUT_NS       = 12_000_000;

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } word_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_POS_W-1:0] position;
        logic                 overflowed;
    } match_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_A_LOW;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic                  op         = OP_CONTROL;
    logic [7:0]            byte_value = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic                  found;
    logic [OUT_POS_W-1:0]  match_position;
    logic                  set_overflowed;

    word_t       stim_q[$];
    match_t      pending_matches[$];
    int unsigned words_queued   = 0;
    int unsigned words_taken    = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;

    // lead byte ranges as the block holds them
    logic [7:0] range_a_lo = RST_A_LOW;
    logic [7:0] range_a_hi = RST_A_HIGH;
    logic [7:0] range_b_lo = RST_B_LOW;
    logic [7:0] range_b_hi = RST_B_HIGH;

    // control set and scan state
    logic [7:0]  set_lead  [SET_CAP];
    logic [7:0]  set_trail [SET_CAP];
    logic        set_pair  [SET_CAP];
    int unsigned set_count     = 0;
    logic        ctl_lead_pend = 1'b0;
    logic [7:0]  ctl_lead      = '0;
    logic        ctl_closed    = 1'b1;
    logic        set_ovf       = 1'b0;
    logic        str_lead_pend = 1'b0;
    logic [7:0]  str_lead      = '0;
    int unsigned scan_pos      = 0;
    logic        scan_done     = 1'b0;

    dbcs_charset_first_match DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .byte_value     (byte_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_position (match_position),
        .set_overflowed (set_overflowed)
    );

    always #6 clk = ~clk;

    function automatic logic lead_byte(input logic [7:0] b);
        return ((range_a_lo <= b) && (b <= range_a_hi)) ||
               ((range_b_lo <= b) && (b <= range_b_hi));
    endfunction

    task automatic store_entry(input logic [7:0] lead, input logic [7:0] trail,
                               input logic pair);
        if (set_count >= SET_CAP)
        begin
            set_ovf = 1'b1;
        end
        else
        begin
            set_lead[set_count]  = lead;
            set_trail[set_count] = trail;
            set_pair[set_count]  = pair;
            set_count++;
        end
    endtask

    function automatic logic set_has(input logic [7:0] lead, input logic [7:0] trail,
                                     input logic pair);
        for (int i = 0; i < set_count; i++)
        begin
            if (set_pair[i] == pair && set_lead[i] == lead && (!pair || set_trail[i] == trail))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic restart_scan();
        str_lead_pend = 1'b0;
        scan_pos      = 0;
        scan_done     = 1'b0;
    endtask

    task automatic bump_pos(input int unsigned n);
        scan_pos = (scan_pos > POS_MAX - n) ? POS_MAX : scan_pos + n;
    endtask

    // Advances the search by one accepted word; queues the result it causes.
    task automatic search_step(input logic word_op, input logic [7:0] b);
        match_t res;
        logic   done;
        logic   hit;
        done = 1'b0;
        hit  = 1'b0;
        if (word_op == OP_CONTROL)
        begin
            // first control word after a closed set starts a new one and kills the scan
            if (ctl_closed)
            begin
                set_count     = 0;
                ctl_lead_pend = 1'b0;
                set_ovf       = 1'b0;
                ctl_closed    = 1'b0;
                restart_scan();
            end
            if (b == TERMINATOR)
            begin
                ctl_lead_pend = 1'b0;
                ctl_closed    = 1'b1;
            end
            else if (ctl_lead_pend)
            begin
                store_entry(ctl_lead, b, 1'b1);
                ctl_lead_pend = 1'b0;
            end
            else if (lead_byte(b))
            begin
                ctl_lead_pend = 1'b1;
                ctl_lead      = b;
            end
            else
            begin
                store_entry(b, '0, 1'b0);
            end
        end
        else
        begin
            if (scan_done)
                restart_scan();
            if (b == TERMINATOR)
            begin
                done = 1'b1;
            end
            else if (str_lead_pend)
            begin
                if (set_has(str_lead, b, 1'b1))
                begin
                    done = 1'b1;
                    hit  = 1'b1;
                end
                else
                begin
                    str_lead_pend = 1'b0;
                    bump_pos(2);
                end
            end
            else if (lead_byte(b))
            begin
                str_lead_pend = 1'b1;
                str_lead      = b;
            end
            else if (set_has(b, '0, 1'b0))
            begin
                done = 1'b1;
                hit  = 1'b1;
            end
            else
            begin
                bump_pos(1);
            end
            if (done)
            begin
                res.found      = hit;
                res.position   = hit ? scan_pos[OUT_POS_W-1:0] : '0;
                res.overflowed = set_ovf;
                pending_matches.push_back(res);
                str_lead_pend = 1'b0;
                scan_done     = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic push_word(input logic word_op, input logic [7:0] value);
        word_t w;
        w.op    = word_op;
        w.value = value;
        stim_q.push_back(w);
        words_queued++;
    endtask

    // Finds a nonzero byte that is (or is not) a lead byte under the current ranges.
    function automatic logic pick_byte(input logic want_lead, output logic [7:0] b);
        logic [7:0]  c;
        int unsigned s;
        b = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = 8'($urandom_range(1, 255));
            if (lead_byte(c) == want_lead)
            begin
                b = c;
                return 1'b1;
            end
        end
        s = $urandom_range(0, 254);
        for (int i = 0; i < 255; i++)
        begin
            c = 8'(((s + i) % 255) + 1);
            if (lead_byte(c) == want_lead)
            begin
                b = c;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic queue_any_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        push_word(OP_STRING, c);
        if (lead_byte(c))
            push_word(OP_STRING, 8'($urandom_range(1, 255)));
    endtask

    task automatic queue_random_words(input int unsigned count);
        logic [7:0]  ent_lead[$];
        logic [7:0]  ent_trail[$];
        logic        ent_pair[$];
        logic [7:0]  c;
        logic [7:0]  t;
        int unsigned start;
        int unsigned n_entries;
        int unsigned k;
        start = words_queued;
        while (words_queued - start < count)
        begin
            if ($urandom_range(99) < 75)
            begin
                ent_lead.delete();
                ent_trail.delete();
                ent_pair.delete();
                n_entries = ($urandom_range(7) == 0) ? $urandom_range(SET_CAP + 1, SET_CAP + 8)
                                                     : $urandom_range(0, 12);
                for (int e = 0; e < n_entries; e++)
                begin
                    if ($urandom_range(1) == 1 && pick_byte(1'b1, c))
                    begin
                        t = 8'($urandom_range(1, 255));
                        push_word(OP_CONTROL, c);
                        push_word(OP_CONTROL, t);
                        ent_lead.push_back(c);
                        ent_trail.push_back(t);
                        ent_pair.push_back(1'b1);
                    end
                    else if (pick_byte(1'b0, c))
                    begin
                        push_word(OP_CONTROL, c);
                        ent_lead.push_back(c);
                        ent_trail.push_back('0);
                        ent_pair.push_back(1'b0);
                    end
                end
                // lone lead just before the terminator gets dropped
                if ($urandom_range(7) == 0 && pick_byte(1'b1, c))
                    push_word(OP_CONTROL, c);
                // now and then the set stays open while strings run
                if ($urandom_range(9) != 0)
                    push_word(OP_CONTROL, TERMINATOR);
                repeat ($urandom_range(1, 4))
                begin
                    repeat ($urandom_range(0, 10))
                    begin
                        if (ent_lead.size() != 0 && $urandom_range(3) == 0)
                        begin
                            k = $urandom_range(ent_lead.size() - 1);
                            push_word(OP_STRING, ent_lead[k]);
                            if (ent_pair[k])
                                push_word(OP_STRING, ent_trail[k]);
                        end
                        else
                        begin
                            queue_any_char();
                        end
                    end
                    if ($urandom_range(7) == 0 && pick_byte(1'b1, c))
                        push_word(OP_STRING, c);
                    push_word(OP_STRING, TERMINATOR);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    c = ($urandom_range(5) == 0) ? TERMINATOR : 8'($urandom_range(1, 255));
                    push_word(1'($urandom_range(1)), c);
                end
            end
        end
    endtask

    task automatic write_ranges(input logic [7:0] a_lo, input logic [7:0] a_hi,
                                input logic [7:0] b_lo, input logic [7:0] b_hi);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_A_LOW;
        cfg_data  <= a_lo;
        @(posedge clk);
        cfg_index <= REG_A_HIGH;
        cfg_data  <= a_hi;
        @(posedge clk);
        cfg_index <= REG_B_LOW;
        cfg_data  <= b_lo;
        @(posedge clk);
        cfg_index <= REG_B_HIGH;
        cfg_data  <= b_hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        range_a_lo = a_lo;
        range_a_hi = a_hi;
        range_b_lo = b_lo;
        range_b_hi = b_hi;
    endtask

    // control words give no result, so also settle past the last one
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (words_taken != words_queued || pending_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : drive_words
        word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = stim_q.pop_front();
                in_valid   <= 1'b1;
                op         <= w.op;
                byte_value <= w.value;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : watch_words
        match_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_matches.size() == 0)
                begin
                    report_mismatch($sformatf("result with none pending: found=%0b pos=%0d",
                                              found, match_position));
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  found, want.found));
                    if (match_position !== want.position)
                        report_mismatch($sformatf("match_position %0d, expected %0d",
                                                  match_position, want.position));
                    if (set_overflowed !== want.overflowed)
                        report_mismatch($sformatf("set_overflowed %0b, expected %0b",
                                                  set_overflowed, want.overflowed));
                end
            end
            if (in_valid && in_ready)
            begin
                words_taken++;
                search_step(op, byte_value);
            end
        end
    end

    initial
    begin
        static word_t directed_words[24] = '{
            '{OP_CONTROL, 8'h41}, '{OP_CONTROL, 8'h81}, '{OP_CONTROL, 8'h42},
            '{OP_CONTROL, 8'hFF}, '{OP_CONTROL, 8'hE0}, '{OP_CONTROL, TERMINATOR},
            '{OP_STRING, 8'h41},
            '{OP_STRING, 8'h30}, '{OP_STRING, 8'h81}, '{OP_STRING, 8'h42},
            '{OP_STRING, 8'h81}, '{OP_STRING, 8'h41}, '{OP_STRING, 8'hFF},
            '{OP_STRING, 8'h9F}, '{OP_STRING, TERMINATOR},
            '{OP_STRING, 8'h01}, '{OP_STRING, TERMINATOR},
            '{OP_CONTROL, 8'h30}, '{OP_STRING, 8'h31}, '{OP_STRING, 8'h30},
            '{OP_STRING, 8'h32}, '{OP_CONTROL, TERMINATOR},
            '{OP_CONTROL, 8'h33}, '{OP_CONTROL, TERMINATOR}
        };
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset ranges: pairs, dropped lead, lead before end, open set, scan aborted
        send_idle_pct = 23;
        recv_idle_pct = 87;
        foreach (directed_words[i])
            push_word(directed_words[i].op, directed_words[i].value);
        push_word(OP_STRING, 8'h33);
        wait_quiet();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            send_idle_pct = (seg < 3) ? 23 : (seg < 6) ? 87 : 0;
            recv_idle_pct = (seg < 3) ? 87 : (seg < 6) ? 23 : 0;
            case (seg)
                0, 6:    write_ranges(RST_A_LOW, RST_A_HIGH, RST_B_LOW, RST_B_HIGH);
                1:       write_ranges(8'd0, 8'd255, 8'd0, 8'd255);
                2:       write_ranges(8'd255, 8'd0, 8'd255, 8'd0);
                3:       write_ranges(8'd1, 8'd1, 8'd255, 8'd255);
                7:       write_ranges(8'd255, 8'd0, 8'd1, 8'd255);
                default: write_ranges(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            queue_random_words(SEGMENT_WORDS);
            wait_quiet();
        end

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
